// File: sv/bmsd_pkg.sv
// Shared types, constants and the Morse character table for the Morse stream decoder.
`default_nettype none

package bmsd_pkg;

  localparam int MAX_CODE_BITS_DEF = 14;

  localparam int BYTE_W  = 8;
  localparam int CHAR_W  = 7;
  localparam int DROP_W  = 8;
  localparam int TDATA_W = 16;

  localparam int ROM_DEPTH     = 46;
  localparam int ROM_CODE_BITS = 14;
  localparam int ROM_LEN_W     = 4;

  localparam logic [DROP_W-1:0] DROP_MAX     = '1;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 7'd32;
  localparam logic [CHAR_W-1:0] UNKNOWN_CHAR = 7'd0;

  // Symbol codes, two bits each.
  localparam logic [1:0] SYM_END_LETTER = 2'b00;
  localparam logic [1:0] SYM_DASH       = 2'b01;
  localparam logic [1:0] SYM_DOT        = 2'b10;
  localparam logic [1:0] SYM_END_WORD   = 2'b11;

  // One queued byte of four symbols.
  typedef struct packed {
    logic [BYTE_W-1:0] sym_byte;
  } q_item_t;

  typedef struct packed {
    logic [ROM_LEN_W-1:0]     len;
    logic [ROM_CODE_BITS-1:0] code;
    logic [CHAR_W-1:0]        ch;
  } rom_entry_t;

  // Dot is 10, dash is 01, first mark in the highest bits.
  localparam rom_entry_t ROM [ROM_DEPTH] = '{
    '{4'd4,  14'b10_01,                7'h41},
    '{4'd8,  14'b01_10_10_10,          7'h42},
    '{4'd8,  14'b01_10_01_10,          7'h43},
    '{4'd6,  14'b01_10_10,             7'h44},
    '{4'd2,  14'b10,                   7'h45},
    '{4'd8,  14'b10_10_01_10,          7'h46},
    '{4'd6,  14'b01_01_10,             7'h47},
    '{4'd8,  14'b10_10_10_10,          7'h48},
    '{4'd4,  14'b10_10,                7'h49},
    '{4'd8,  14'b10_01_01_01,          7'h4A},
    '{4'd6,  14'b01_10_01,             7'h4B},
    '{4'd8,  14'b10_01_10_10,          7'h4C},
    '{4'd4,  14'b01_01,                7'h4D},
    '{4'd4,  14'b01_10,                7'h4E},
    '{4'd6,  14'b01_01_01,             7'h4F},
    '{4'd8,  14'b10_01_01_10,          7'h50},
    '{4'd8,  14'b01_01_10_01,          7'h51},
    '{4'd6,  14'b10_01_10,             7'h52},
    '{4'd6,  14'b10_10_10,             7'h53},
    '{4'd2,  14'b01,                   7'h54},
    '{4'd6,  14'b10_10_01,             7'h55},
    '{4'd8,  14'b10_10_10_01,          7'h56},
    '{4'd6,  14'b10_01_01,             7'h57},
    '{4'd8,  14'b01_10_10_01,          7'h58},
    '{4'd8,  14'b01_10_01_01,          7'h59},
    '{4'd8,  14'b01_01_10_10,          7'h5A},
    '{4'd10, 14'b01_01_01_01_01,       7'h30},
    '{4'd10, 14'b10_01_01_01_01,       7'h31},
    '{4'd10, 14'b10_10_01_01_01,       7'h32},
    '{4'd10, 14'b10_10_10_01_01,       7'h33},
    '{4'd10, 14'b10_10_10_10_01,       7'h34},
    '{4'd10, 14'b10_10_10_10_10,       7'h35},
    '{4'd10, 14'b01_10_10_10_10,       7'h36},
    '{4'd10, 14'b01_01_10_10_10,       7'h37},
    '{4'd10, 14'b01_01_01_10_10,       7'h38},
    '{4'd10, 14'b01_01_01_01_10,       7'h39},
    '{4'd12, 14'b10_01_01_01_01_10,    7'h27},
    '{4'd12, 14'b10_01_01_10_01_10,    7'h40},
    '{4'd12, 14'b01_01_01_10_10_10,    7'h3A},
    '{4'd12, 14'b01_01_10_10_01_01,    7'h2C},
    '{4'd14, 14'b10_10_10_01_10_10_01, 7'h24},
    '{4'd10, 14'b01_10_10_10_01,       7'h3D},
    '{4'd12, 14'b01_10_01_10_01_01,    7'h21},
    '{4'd12, 14'b10_01_10_01_10_01,    7'h2E},
    '{4'd12, 14'b10_10_01_01_10_10,    7'h3F},
    '{4'd12, 14'b10_01_10_10_01_10,    7'h22}
  };

  // Codes in the table are unique, so at most one entry matches.
  function automatic logic [CHAR_W-1:0] rom_lookup(input logic [ROM_CODE_BITS-1:0] code,
                                                   input logic [ROM_LEN_W-1:0]     len);
    logic [CHAR_W-1:0] ch;
    ch = UNKNOWN_CHAR;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      if (ROM[i].len == len && ROM[i].code == code) begin
        ch = ROM[i].ch;
      end
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: sv/binary_morse_stream_decoder_core.sv
// A byte is written into the byte queue on its beat and reaches the symbol stepper from there;
// a result it causes is registered in the output register.
// Throughput: one symbol per cycle while a byte is queued and the output is not stalled, plus
// an extra step for each word end that follows a kept code; the single symbol stepper sets this rate.
// A two-entry byte queue sits between input and stepper, and one output register follows it.
// Reset (rst, synchronous) clears the code, length, dropped count, symbol index, pending space, queue and output valid.
`default_nettype none

module binary_morse_stream_decoder_core #(
  parameter int MAX_CODE_BITS = bmsd_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [bmsd_pkg::BYTE_W-1:0]  s_tdata,   // in_byte
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [bmsd_pkg::TDATA_W-1:0]      m_tdata,   // out_char, dropped_count, zero pad
  output logic                              m_tlast    // last_of_byte
);

  logic              head_valid;
  bmsd_pkg::q_item_t head;
  logic              pop;

  bmsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  bmsd_back #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// File: sv/bmsd_front.sv
// Input side: accepts bytes and queues them for the symbol stepper.
`default_nettype none

module bmsd_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [bmsd_pkg::BYTE_W-1:0] s_tdata,    // in_byte
  output logic                             head_valid,
  output bmsd_pkg::q_item_t                head,
  input  wire logic                        pop
);

  bmsd_pkg::q_item_t mem [2];
  bmsd_pkg::q_item_t item;
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;

  assign item.sym_byte = s_tdata;

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// File: sv/bmsd_back.sv
// Execution side: steps through the symbols of each queued byte and emits characters.
`default_nettype none

module bmsd_back #(
  parameter int MAX_CODE_BITS = bmsd_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         head_valid,
  input  wire bmsd_pkg::q_item_t            head,
  output logic                              pop,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [bmsd_pkg::TDATA_W-1:0]      m_tdata,    // out_char, dropped_count, zero pad
  output logic                              m_tlast     // last_of_byte
);

  localparam int LW  = $clog2(MAX_CODE_BITS + 2);
  localparam int LXW = (LW + 1 > 5) ? LW + 1 : 5;
  localparam int XW  = (MAX_CODE_BITS > bmsd_pkg::ROM_CODE_BITS) ?
                       MAX_CODE_BITS : bmsd_pkg::ROM_CODE_BITS;

  logic [MAX_CODE_BITS-1:0]       code_bits;
  logic [MAX_CODE_BITS-1:0]       code_bits_next;
  logic [LW-1:0]                  code_len;
  logic [LW-1:0]                  code_len_next;
  logic [bmsd_pkg::DROP_W-1:0]    dropped;
  logic [bmsd_pkg::DROP_W-1:0]    dropped_next;
  logic [1:0]                     idx;
  logic                           space_pend;
  logic                           space_pend_next;

  logic [1:0]                     sym;
  logic [LXW-1:0]                 len_x;
  logic [XW-1:0]                  code_x;
  logic                           code_ok;
  logic [bmsd_pkg::CHAR_W-1:0]    rom_char;
  logic                           emit;
  logic [bmsd_pkg::CHAR_W-1:0]    emit_char;
  logic                           emit_last;
  logic                           advance;
  logic                           out_free;
  logic                           fire;
  logic [1:0]                     later_sym;
  logic [1:0]                     later_marks;
  logic                           more_after;

  always_comb begin
    case (idx)
      2'd0:    sym = head.sym_byte[7:6];
      2'd1:    sym = head.sym_byte[5:4];
      2'd2:    sym = head.sym_byte[3:2];
      default: sym = head.sym_byte[1:0];
    endcase
  end

  // Separators after the current one start from an empty code, so whether any of them
  // still yields a result depends on this byte alone.
  always_comb begin
    more_after  = 1'b0;
    later_marks = '0;
    later_sym   = bmsd_pkg::SYM_END_LETTER;
    for (int k = 1; k < 4; k++) begin
      if (2'(k) > idx) begin
        later_sym = head.sym_byte[7-2*k -: 2];
        if (later_sym == bmsd_pkg::SYM_DOT || later_sym == bmsd_pkg::SYM_DASH) begin
          later_marks = later_marks + 2'd1;
        end else begin
          if (later_sym == bmsd_pkg::SYM_END_WORD ||
              (later_marks != '0 && 2 * int'(later_marks) <= MAX_CODE_BITS)) begin
            more_after = 1'b1;
          end
          later_marks = '0;
        end
      end
    end
  end

  assign len_x   = LXW'(code_len);
  assign code_x  = XW'(code_bits);
  assign code_ok = (len_x != '0) && (len_x <= LXW'(MAX_CODE_BITS));

  // Codes longer than any table entry cannot match.
  assign rom_char = (len_x <= LXW'(bmsd_pkg::ROM_CODE_BITS)) ?
                    bmsd_pkg::rom_lookup(code_x[bmsd_pkg::ROM_CODE_BITS-1:0],
                                         len_x[bmsd_pkg::ROM_LEN_W-1:0]) :
                    bmsd_pkg::UNKNOWN_CHAR;

  always_comb begin
    emit            = 1'b0;
    emit_char       = bmsd_pkg::UNKNOWN_CHAR;
    emit_last       = 1'b0;
    advance         = 1'b0;
    code_bits_next  = code_bits;
    code_len_next   = code_len;
    dropped_next    = dropped;
    space_pend_next = space_pend;
    if (space_pend) begin
      emit            = 1'b1;
      emit_char       = bmsd_pkg::SPACE_CHAR;
      emit_last       = !more_after;
      space_pend_next = 1'b0;
      advance         = 1'b1;
    end else begin
      case (sym) inside
        bmsd_pkg::SYM_DOT, bmsd_pkg::SYM_DASH: begin
          advance = 1'b1;
          if (len_x + LXW'(2) <= LXW'(MAX_CODE_BITS)) begin
            code_bits_next = (code_bits << 2) | MAX_CODE_BITS'(sym);
            code_len_next  = code_len + LW'(2);
          end else begin
            code_len_next = LW'(MAX_CODE_BITS + 1);
          end
        end
        default: begin
          code_bits_next = '0;
          code_len_next  = '0;
          if (code_ok) begin
            emit      = 1'b1;
            emit_char = rom_char;
            // A word end after a kept code needs a second step for the space.
            if (sym == bmsd_pkg::SYM_END_WORD) begin
              space_pend_next = 1'b1;
            end else begin
              emit_last = !more_after;
              advance   = 1'b1;
            end
          end else begin
            if (dropped != bmsd_pkg::DROP_MAX) begin
              dropped_next = dropped + 1'b1;
            end
            if (sym == bmsd_pkg::SYM_END_WORD) begin
              emit      = 1'b1;
              emit_char = bmsd_pkg::SPACE_CHAR;
              emit_last = !more_after;
            end
            advance = 1'b1;
          end
        end
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign fire     = head_valid && (!emit || out_free);
  assign pop      = fire && advance && (idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits  <= '0;
      code_len   <= '0;
      dropped    <= '0;
      idx        <= 2'd0;
      space_pend <= 1'b0;
    end else if (fire) begin
      code_bits  <= code_bits_next;
      code_len   <= code_len_next;
      dropped    <= dropped_next;
      space_pend <= space_pend_next;
      if (advance) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      m_tdata <= {1'b0, dropped_next, emit_char};
      m_tlast <= emit_last;
    end
  end

endmodule

`default_nettype wire

// File: sv/bmsd_checker.sv
// Port-level checks for the Morse stream decoder, bound to its top level.
`default_nettype none

module bmsd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [bmsd_pkg::TDATA_W-1:0] m_tdata,
  input wire logic                        m_tlast
);

  logic                        seen;
  logic [bmsd_pkg::DROP_W-1:0] last_drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      last_drop <= '0;
    end else if (m_tvalid && m_tready) begin
      seen      <= 1'b1;
      last_drop <= m_tdata[14:7];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[15])
    else $error("padding bit of output beat set");

  a_drop_monotone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && seen |-> m_tdata[14:7] >= last_drop)
    else $error("dropped count went backwards");

endmodule

bind binary_morse_stream_decoder_core bmsd_checker u_bmsd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
